>>> src/mlfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mlfs_pkg;

	localparam int MAX_TASKS  = 16;
	localparam int LEVELS     = 3;
	localparam int TID_W      = $clog2(MAX_TASKS);
	localparam int LVL_W      = $clog2(LEVELS);
	localparam int CNT_W      = $clog2(MAX_TASKS + 1);
	localparam int WORK_W     = 16;
	localparam int BASE_W     = 8;
	localparam int QNT_W      = BASE_W + LVL_W;
	localparam int QRAM_DEPTH = LEVELS * MAX_TASKS;
	localparam int QADDR_W    = $clog2(QRAM_DEPTH);
	localparam int MASK_W     = 16;
	localparam int ADDR_W     = 3;
	localparam int DATA_W     = 32;

	localparam logic [BASE_W-1:0] BASE_RESET = 8'd4;
	localparam logic              REG_BASE_QUANTUM = 1'b0;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE    = 2'd0,
		ST_READY   = 2'd1,
		ST_RUNNING = 2'd2,
		ST_TERM    = 2'd3
	} status_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic             in_fire;
		logic             chg_rd;
		logic             chg_upd;
		logic             arr;
		logic [TID_W-1:0] arr_idx;
		logic             el_rd;
		logic             el_upd;
	} dp_cmd_t;

	typedef struct packed {
		logic out_busy;
	} dp_sts_t;

	function automatic logic [QADDR_W-1:0] qaddr(input logic [LVL_W-1:0] lvl,
		input logic [TID_W-1:0] ptr);
		qaddr = QADDR_W'(lvl) * QADDR_W'(MAX_TASKS) + QADDR_W'(ptr);
	endfunction

endpackage
`default_nettype wire

>>> src/mlfs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module mlfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

>>> src/mlfs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module mlfs_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             cmd,
	input  wire mlfs_pkg::dp_sts_t sts,
	output mlfs_pkg::dp_cmd_t     dcmd
);
	typedef enum logic [2:0] {
		S_IDLE, S_CHG0, S_CHG1, S_ARR, S_EL0, S_EL1
	} state_t;

	state_t                       state_q;
	logic [mlfs_pkg::TID_W-1:0]   idx_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		dcmd         = '0;
		dcmd.in_fire = in_valid && in_ready;
		dcmd.arr_idx = idx_q;
		case (state_q)
			S_CHG0:  dcmd.chg_rd = 1'b1;
			S_CHG1:  dcmd.chg_upd = 1'b1;
			S_ARR:   dcmd.arr = 1'b1;
			S_EL0:   dcmd.el_rd = 1'b1;
			S_EL1:   dcmd.el_upd = !sts.out_busy;
			default: dcmd.in_fire = in_valid && in_ready;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid && cmd == mlfs_pkg::CMD_TICK) begin
						state_q <= S_CHG0;
					end
				end
				S_CHG0: state_q <= S_CHG1;
				S_CHG1: begin
					idx_q   <= '0;
					state_q <= S_ARR;
				end
				S_ARR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == mlfs_pkg::TID_W'(mlfs_pkg::MAX_TASKS - 1)) begin
						state_q <= S_EL0;
					end
				end
				S_EL0: state_q <= S_EL1;
				S_EL1: begin
					// hold until the output register is free
					if (!sts.out_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> src/mlfs_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module mlfs_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mlfs_pkg::dp_cmd_t             dcmd,
	output mlfs_pkg::dp_sts_t                  sts,
	input  wire logic                          cmd,
	input  wire logic [mlfs_pkg::TID_W-1:0]    task_id,
	input  wire logic [mlfs_pkg::WORK_W-1:0]   work_needed,
	input  wire logic [mlfs_pkg::MASK_W-1:0]   arrival_mask,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               elected_valid,
	output logic [mlfs_pkg::TID_W-1:0]         elected_task,
	output logic [mlfs_pkg::LVL_W-1:0]         elected_level,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [mlfs_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [mlfs_pkg::DATA_W-1:0]   pwdata,
	output logic [mlfs_pkg::DATA_W-1:0]        prdata
);
	localparam int N = mlfs_pkg::MAX_TASKS;
	localparam int L = mlfs_pkg::LEVELS;

	logic [mlfs_pkg::BASE_W-1:0]  base_q;
	logic [mlfs_pkg::TID_W-1:0]   head_q [L];
	logic [mlfs_pkg::TID_W-1:0]   tail_q [L];
	logic [mlfs_pkg::CNT_W-1:0]   cnt_q  [L];
	logic [mlfs_pkg::WORK_W-1:0]  need_q [N];
	logic [mlfs_pkg::WORK_W-1:0]  done_q [N];
	logic [mlfs_pkg::QNT_W-1:0]   qnt_q  [N];
	mlfs_pkg::status_t            stat_q [N];
	logic [mlfs_pkg::LVL_W-1:0]   cur_q;
	logic                         run_q;
	logic                         go_q;
	logic [mlfs_pkg::TID_W-1:0]   prev_q;
	logic                         had_prev_q;
	logic [mlfs_pkg::MASK_W-1:0]  mask_q;
	logic [mlfs_pkg::LVL_W-1:0]   el_lvl_q;
	logic                         el_any_q;
	logic                         out_valid_q;
	logic                         ev_q;
	logic [mlfs_pkg::TID_W-1:0]   et_q;
	logic [mlfs_pkg::LVL_W-1:0]   el_q;

	logic                         ram_we;
	logic [mlfs_pkg::QADDR_W-1:0] ram_waddr;
	logic [mlfs_pkg::QADDR_W-1:0] ram_raddr;
	logic                         ram_re;
	logic [mlfs_pkg::TID_W-1:0]   ram_rdata;

	logic [mlfs_pkg::BASE_W-1:0]  eb;
	logic [mlfs_pkg::TID_W-1:0]   t;
	logic [mlfs_pkg::WORK_W-1:0]  dn;
	logic [mlfs_pkg::QNT_W-1:0]   qn;
	logic [mlfs_pkg::LVL_W-1:0]   nxt;
	logic                         c_term;
	logic                         c_demote;
	logic                         push_en;
	logic [mlfs_pkg::LVL_W-1:0]   push_lvl;
	logic                         pop_en;
	logic                         arr_hit;
	logic [mlfs_pkg::LVL_W-1:0]   sel_lvl;
	logic                         sel_any;
	logic                         cfg_we;
	logic [N-1:0]                 running;

	assign eb = (base_q == '0) ? mlfs_pkg::BASE_W'(1) : base_q;
	assign t  = ram_rdata;

	// charge arithmetic on the front task of the running level
	always_comb begin
		dn = (done_q[t] == '1) ? done_q[t] : done_q[t] + 1'b1;
		qn = (qnt_q[t] == '0) ? '0 : qnt_q[t] - 1'b1;
		nxt = (cur_q == mlfs_pkg::LVL_W'(L - 1)) ? '0 : cur_q + 1'b1;
		c_term   = (dn >= need_q[t]);
		c_demote = !c_term && (qn == '0);
		arr_hit  = mask_q[dcmd.arr_idx] && (stat_q[dcmd.arr_idx] == mlfs_pkg::ST_IDLE);
	end

	always_comb begin
		sel_any = 1'b0;
		sel_lvl = '0;
		for (int l = L - 1; l >= 0; l--) begin
			if (cnt_q[l] != '0) begin
				sel_any = 1'b1;
				sel_lvl = mlfs_pkg::LVL_W'(l);
			end
		end
	end

	always_comb begin
		push_en  = 1'b0;
		push_lvl = '0;
		pop_en   = 1'b0;
		if (dcmd.chg_upd && go_q && (c_term || c_demote)) begin
			pop_en = 1'b1;
			if (c_demote) begin
				push_en  = 1'b1;
				push_lvl = nxt;
			end
		end else if (dcmd.arr && arr_hit) begin
			push_en = 1'b1;
		end
		// drop a push into a full queue
		if (cnt_q[push_lvl] >= mlfs_pkg::CNT_W'(N)) begin
			push_en = 1'b0;
		end
		ram_we    = push_en;
		ram_waddr = mlfs_pkg::qaddr(push_lvl, tail_q[push_lvl]);
		ram_re    = dcmd.chg_rd || dcmd.el_rd;
		ram_raddr = dcmd.el_rd ? mlfs_pkg::qaddr(sel_lvl, head_q[sel_lvl])
		                       : mlfs_pkg::qaddr(cur_q, head_q[cur_q]);
	end

	mlfs_ram #(
		.WIDTH(mlfs_pkg::TID_W),
		.DEPTH(mlfs_pkg::QRAM_DEPTH)
	) u_qram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (dcmd.arr ? dcmd.arr_idx : t),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cfg_we = psel && penable && pwrite && (paddr[2] == mlfs_pkg::REG_BASE_QUANTUM);
	assign prdata = (paddr[2] == mlfs_pkg::REG_BASE_QUANTUM)
	                ? mlfs_pkg::DATA_W'(base_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= mlfs_pkg::BASE_RESET;
		end else if (cfg_we) begin
			base_q <= pwdata[mlfs_pkg::BASE_W-1:0];
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < L; l++) begin
				head_q[l] <= '0;
				tail_q[l] <= '0;
				cnt_q[l]  <= '0;
			end
		end else begin
			for (int l = 0; l < L; l++) begin
				if (push_en && push_lvl == mlfs_pkg::LVL_W'(l)) begin
					tail_q[l] <= tail_q[l] + 1'b1;
				end
				if (pop_en && cur_q == mlfs_pkg::LVL_W'(l)) begin
					head_q[l] <= head_q[l] + 1'b1;
				end
				cnt_q[l] <= cnt_q[l]
					+ mlfs_pkg::CNT_W'(push_en && push_lvl == mlfs_pkg::LVL_W'(l))
					- mlfs_pkg::CNT_W'(pop_en && cur_q == mlfs_pkg::LVL_W'(l));
			end
		end
	end

	// work needed has no reset
	always_ff @(posedge clk) begin
		if (dcmd.in_fire && cmd == mlfs_pkg::CMD_LOAD &&
		    (stat_q[task_id] == mlfs_pkg::ST_IDLE || stat_q[task_id] == mlfs_pkg::ST_TERM)) begin
			need_q[task_id] <= work_needed;
		end
		if (dcmd.in_fire) begin
			mask_q <= arrival_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				done_q[i] <= '0;
				qnt_q[i]  <= '0;
				stat_q[i] <= mlfs_pkg::ST_IDLE;
			end
			cur_q       <= '0;
			run_q       <= 1'b0;
			go_q        <= 1'b0;
			prev_q      <= '0;
			had_prev_q  <= 1'b0;
			el_lvl_q    <= '0;
			el_any_q    <= 1'b0;
			out_valid_q <= 1'b0;
			ev_q        <= 1'b0;
			et_q        <= '0;
			el_q        <= '0;
		end else begin
			if (dcmd.in_fire && cmd == mlfs_pkg::CMD_LOAD &&
			    (stat_q[task_id] == mlfs_pkg::ST_IDLE ||
			     stat_q[task_id] == mlfs_pkg::ST_TERM)) begin
				done_q[task_id] <= '0;
				stat_q[task_id] <= mlfs_pkg::ST_IDLE;
			end
			if (dcmd.chg_rd) begin
				go_q       <= run_q && (cnt_q[cur_q] != '0);
				had_prev_q <= 1'b0;
			end
			if (dcmd.chg_upd && go_q) begin
				done_q[t] <= dn;
				if (c_term) begin
					qnt_q[t]  <= qn;
					stat_q[t] <= mlfs_pkg::ST_TERM;
				end else if (c_demote) begin
					stat_q[t] <= mlfs_pkg::ST_READY;
					qnt_q[t]  <= mlfs_pkg::QNT_W'(
						(mlfs_pkg::QNT_W'(nxt) + 1'b1) * mlfs_pkg::QNT_W'(eb));
				end else begin
					qnt_q[t]   <= qn;
					prev_q     <= t;
					had_prev_q <= 1'b1;
				end
			end
			if (dcmd.arr && arr_hit) begin
				stat_q[dcmd.arr_idx] <= mlfs_pkg::ST_READY;
				qnt_q[dcmd.arr_idx]  <= mlfs_pkg::QNT_W'(eb);
			end
			if (dcmd.el_rd) begin
				el_lvl_q <= sel_lvl;
				el_any_q <= sel_any;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (dcmd.el_upd) begin
				run_q       <= el_any_q;
				out_valid_q <= 1'b1;
				ev_q        <= el_any_q;
				et_q        <= el_any_q ? t : '0;
				el_q        <= el_any_q ? el_lvl_q : '0;
				if (el_any_q) begin
					cur_q <= el_lvl_q;
					// return a preempted task to ready
					if (had_prev_q && prev_q != t &&
					    stat_q[prev_q] == mlfs_pkg::ST_RUNNING) begin
						stat_q[prev_q] <= mlfs_pkg::ST_READY;
					end
					stat_q[t] <= mlfs_pkg::ST_RUNNING;
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < N; i++) begin
			running[i] = (stat_q[i] == mlfs_pkg::ST_RUNNING);
		end
	end

	assign sts.out_busy  = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign elected_valid = ev_q;
	assign elected_task  = et_q;
	assign elected_level = el_q;

	a_one_running: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(running))
		else $error("more than one task running");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q[0] <= mlfs_pkg::CNT_W'(N)) && (cnt_q[1] <= mlfs_pkg::CNT_W'(N)) &&
		(cnt_q[2] <= mlfs_pkg::CNT_W'(N)))
		else $error("queue count beyond depth");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !ev_q) |-> (et_q == '0 && el_q == '0))
		else $error("empty election carries a task");

	a_run_elected: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.el_upd |=> (run_q == ev_q))
		else $error("running flag differs from election");
endmodule
`default_nettype wire

>>> src/multilevel_feedback_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// Three-level feedback scheduler, level 0 highest.
// Input channel (in_valid/in_ready): cmd 1 loads work_needed for task_id and
// gives no result; cmd 0 is a tick that charges the running task, admits the
// idle tasks in arrival_mask and elects the front of the highest busy level.
// Output channel (out_valid/out_ready): one result per tick, elected_valid,
// elected_task and elected_level (task and level 0 when nothing is elected).
// A load is taken without leaving the idle state. A tick passes through the
// charge read and update of the queue memory, the arrival scan over all
// sixteen tasks (one task a cycle), the election read and the registered
// result, and no item is taken until it is back in idle; the next item can
// be taken in the same cycle as the result appears. The result sits in an
// output register; the next item is taken while it waits, and a following
// tick holds at its election until the result is taken. base_quantum is
// written through the APB port at address 0. Reset clears the queues, the
// tables other than work needed, and the output register; base_quantum
// returns to 4. The queue memory needs no clearing pass.
module multilevel_feedback_scheduler (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          cmd,
	input  wire logic [mlfs_pkg::TID_W-1:0]    task_id,
	input  wire logic [mlfs_pkg::WORK_W-1:0]   work_needed,
	input  wire logic [mlfs_pkg::MASK_W-1:0]   arrival_mask,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               elected_valid,
	output logic [mlfs_pkg::TID_W-1:0]         elected_task,
	output logic [mlfs_pkg::LVL_W-1:0]         elected_level,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [mlfs_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [mlfs_pkg::DATA_W-1:0]   pwdata,
	output logic [mlfs_pkg::DATA_W-1:0]        prdata,
	output logic                               pready
);
	mlfs_pkg::dp_cmd_t dcmd;
	mlfs_pkg::dp_sts_t sts;

	assign pready = 1'b1;

	mlfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts),
		.dcmd     (dcmd)
	);

	mlfs_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.dcmd          (dcmd),
		.sts           (sts),
		.cmd           (cmd),
		.task_id       (task_id),
		.work_needed   (work_needed),
		.arrival_mask  (arrival_mask),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.elected_valid (elected_valid),
		.elected_task  (elected_task),
		.elected_level (elected_level),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata)
	);
endmodule
`default_nettype wire

>>> dv/multilevel_feedback_scheduler_tb.sv
`timescale 1ns / 1ps
module multilevel_feedback_scheduler_tb;

	localparam int MAX_TASKS = mlfs_pkg::MAX_TASKS;
	localparam int LEVELS    = mlfs_pkg::LEVELS;
	localparam int TID_W     = mlfs_pkg::TID_W;
	localparam int LVL_W     = mlfs_pkg::LVL_W;
	localparam int WORK_W    = mlfs_pkg::WORK_W;
	localparam int MASK_W    = mlfs_pkg::MASK_W;
	localparam int ADDR_W    = mlfs_pkg::ADDR_W;
	localparam int DATA_W    = mlfs_pkg::DATA_W;
	localparam int BASE_W    = mlfs_pkg::BASE_W;
	localparam logic CMD_TICK = mlfs_pkg::CMD_TICK;
	localparam logic CMD_LOAD = mlfs_pkg::CMD_LOAD;

	localparam int CYCLE_LIMIT = 500000;
	localparam logic [ADDR_W-1:0] BASE_ADDR = ADDR_W'(int'(mlfs_pkg::REG_BASE_QUANTUM) * 4);

	typedef struct {
		logic             valid;
		logic [TID_W-1:0] tid;
		logic [LVL_W-1:0] lvl;
	} election_t;

	logic clk;
	logic arst_n;
	logic in_valid, in_ready, cmd, out_valid, out_ready;
	logic [TID_W-1:0] task_id;
	logic [WORK_W-1:0] work_needed;
	logic [MASK_W-1:0] arrival_mask;
	logic elected_valid;
	logic [TID_W-1:0] elected_task;
	logic [LVL_W-1:0] elected_level;
	logic psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata, prdata;

	multilevel_feedback_scheduler uut (.*);

	// scheduler shadow state
	logic [TID_W-1:0] lq[LEVELS][MAX_TASKS];
	int head[LEVELS], tail[LEVELS], cnt[LEVELS];
	logic [WORK_W-1:0] need_tbl[MAX_TASKS], done_tbl[MAX_TASKS];
	int unsigned qleft[MAX_TASKS];
	mlfs_pkg::status_t state_tbl[MAX_TASKS];
	int cur_lvl;
	bit run_v;
	int unsigned base_q;
	logic [MASK_W-1:0] loaded;

	election_t elections_due[$];
	bit failed = 0;
	bit quiet = 0;
	int cycles = 0;
	int rx_stall = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void push_lvl(int l, logic [TID_W-1:0] t);
		if (cnt[l] >= MAX_TASKS) return;
		lq[l][tail[l]] = t;
		tail[l] = (tail[l] + 1) % MAX_TASKS;
		cnt[l]++;
	endfunction

	function automatic void pop_lvl(int l);
		if (cnt[l] == 0) return;
		head[l] = (head[l] + 1) % MAX_TASKS;
		cnt[l]--;
	endfunction

	function automatic int unsigned eff_base();
		return (base_q == 0) ? 1 : base_q;
	endfunction

	function automatic void load_task(logic [TID_W-1:0] t, logic [WORK_W-1:0] w);
		if (state_tbl[t] == mlfs_pkg::ST_IDLE || state_tbl[t] == mlfs_pkg::ST_TERM) begin
			need_tbl[t] = w;
			done_tbl[t] = '0;
			state_tbl[t] = mlfs_pkg::ST_IDLE;
		end
		loaded[t] = 1'b1;
	endfunction

	function automatic election_t schedule_tick(logic [MASK_W-1:0] mask);
		election_t r;
		logic [TID_W-1:0] t, prev;
		bit had_prev;
		int l, nxt;
		had_prev = 0;
		prev = '0;
		if (run_v) begin
			l = cur_lvl;
			if (cnt[l] == 0) run_v = 0;
			else begin
				t = lq[l][head[l]];
				if (done_tbl[t] != 16'hFFFF) done_tbl[t]++;
				if (qleft[t] != 0) qleft[t]--;
				if (done_tbl[t] >= need_tbl[t]) begin
					state_tbl[t] = mlfs_pkg::ST_TERM;
					pop_lvl(l);
				end else if (qleft[t] == 0) begin
					// demote, wrapping from the lowest level to the top
					nxt = (l + 1) % LEVELS;
					state_tbl[t] = mlfs_pkg::ST_READY;
					pop_lvl(l);
					qleft[t] = (nxt + 1) * eff_base();
					push_lvl(nxt, t);
				end else begin
					prev = t;
					had_prev = 1;
				end
			end
		end
		for (int i = 0; i < MAX_TASKS; i++)
			if (mask[i] && state_tbl[i] == mlfs_pkg::ST_IDLE) begin
				state_tbl[i] = mlfs_pkg::ST_READY;
				qleft[i] = eff_base();
				push_lvl(0, TID_W'(i));
			end
		r = '{1'b0, '0, '0};
		run_v = 0;
		for (l = 0; l < LEVELS; l++)
			if (cnt[l] != 0) begin
				t = lq[l][head[l]];
				cur_lvl = l;
				run_v = 1;
				state_tbl[t] = mlfs_pkg::ST_RUNNING;
				if (had_prev && prev != t && state_tbl[prev] == mlfs_pkg::ST_RUNNING)
					state_tbl[prev] = mlfs_pkg::ST_READY;
				r = '{1'b1, t, LVL_W'(l)};
				break;
			end
		return r;
	endfunction

	task automatic send_item(logic c, logic [TID_W-1:0] t, logic [WORK_W-1:0] w,
		logic [MASK_W-1:0] m);
		in_valid <= 1'b1;
		cmd <= c;
		task_id <= t;
		work_needed <= w;
		arrival_mask <= m;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (c == CMD_LOAD) load_task(t, w);
		else elections_due.push_back(schedule_tick(m));
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic load(logic [TID_W-1:0] t, logic [WORK_W-1:0] w);
		send_item(CMD_LOAD, t, w, MASK_W'($urandom));
	endtask

	task automatic tick(logic [MASK_W-1:0] m);
		send_item(CMD_TICK, TID_W'($urandom), WORK_W'($urandom), m);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (elections_due.size() != 0) @(posedge clk);
		// a trailing load gives no result; let it settle
		repeat (30) @(posedge clk);
	endtask

	task automatic write_base(logic [DATA_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= BASE_ADDR;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		base_q = v[BASE_W-1:0];
	endtask

	task automatic test_reset_quantum();
		load(4'd0, 16'd9);
		load(4'd1, 16'd2);
		tick('0);
		tick(16'h0003);
		repeat (12) tick('0);
	endtask

	task automatic test_directed();
		for (int i = 0; i < MAX_TASKS; i++) load(TID_W'(i), WORK_W'(i + 1));
		load(4'd15, 16'hFFFF);
		load(4'd14, 16'd0);
		tick(16'hFFFF);
		// busy tasks ignore both loads and arrivals
		load(4'd0, 16'd50);
		tick(16'h0001);
		repeat (6) tick('0);
	endtask

	task automatic test_quantum_extremes();
		logic [DATA_W-1:0] vals[4] = '{32'd1, 32'd255, 32'd0, 32'd3};
		foreach (vals[k]) begin
			write_base(vals[k]);
			for (int i = 0; i < 14; i++) load(TID_W'(i), WORK_W'($urandom_range(1, 20)));
			tick(16'h3FFF);
			repeat (20) tick('0);
			drain();
		end
	endtask

	task automatic test_random();
		int r;
		for (int n = 0; n < 270; n++) begin
			if (n == 220) quiet = 1;
			if (n == 120) begin
				// hold the sender until every election has come back
				in_valid <= 1'b0;
				@(posedge clk);
				while (elections_due.size() != 0) @(posedge clk);
			end
			r = $urandom_range(0, 9);
			if (r < 3)
				load(TID_W'($urandom), ($urandom_range(0, 15) == 0) ? WORK_W'($urandom)
					: WORK_W'($urandom_range(1, 40)));
			else if (r < 5) tick(MASK_W'($urandom) & loaded);
			else tick('0);
		end
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (elections_due.size() == 0) begin
				$error("unexpected election: valid %0d task %0d level %0d",
					elected_valid, elected_task, elected_level);
				failed = 1;
			end else begin
				election_t e;
				e = elections_due.pop_front();
				if (elected_valid !== e.valid) begin
					$error("elected_valid: expected %0d, got %0d", e.valid, elected_valid);
					failed = 1;
				end
				if (elected_task !== e.tid) begin
					$error("elected_task: expected %0d, got %0d", e.tid, elected_task);
					failed = 1;
				end
				if (elected_level !== e.lvl) begin
					$error("elected_level: expected %0d, got %0d", e.lvl, elected_level);
					failed = 1;
				end
			end
		end
		if (rx_stall > 0) rx_stall = rx_stall - 1;
		else if (!quiet && $urandom_range(0, 5) == 0) rx_stall = $urandom_range(1, 4);
		out_ready <= (rx_stall == 0);
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		cmd <= CMD_TICK;
		task_id <= '0;
		work_needed <= '0;
		arrival_mask <= '0;
		out_ready <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		for (int l = 0; l < LEVELS; l++) begin
			head[l] = 0;
			tail[l] = 0;
			cnt[l] = 0;
		end
		for (int i = 0; i < MAX_TASKS; i++) begin
			done_tbl[i] = '0;
			need_tbl[i] = '0;
			qleft[i] = 0;
			state_tbl[i] = mlfs_pkg::ST_IDLE;
		end
		cur_lvl = 0;
		run_v = 0;
		base_q = mlfs_pkg::BASE_RESET;
		loaded = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_quantum();
		test_directed();
		drain();
		test_quantum_extremes();
		test_random();
		drain();
		if (!failed) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end
endmodule
